### hw/rtl/erag_pkg.sv
// Shared types and constants for the ELF relocation address generator.
// No dependencies; erag_seq and the top level refer to this package by scope.
`default_nettype none

package erag_pkg;

	// Entry kinds on the mode field
	typedef enum logic [1:0] {
		MODE_RELA   = 2'd0,
		MODE_REL    = 2'd1,
		MODE_RELR   = 2'd2,
		MODE_UNUSED = 2'd3
	} erag_mode_t;

	// Command codes on the action field
	typedef enum logic [1:0] {
		ACT_STORE = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_SKIP  = 2'd2,
		ACT_NONE  = 2'd3
	} erag_act_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_IMAGE_BASE   = 2'd0,
		CFG_REGION_START = 2'd1,
		CFG_REGION_END   = 2'd2,
		CFG_RSVD         = 2'd3
	} erag_cfg_idx_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_ADDR,
		ST_VAL,
		ST_SCAN,
		ST_EMIT,
		ST_ADV
	} erag_state_t;

	// Relocation types handled
	localparam logic [31:0] RTYPE_ABS64    = 32'd1;
	localparam logic [31:0] RTYPE_GLOB_DAT = 32'd6;
	localparam logic [31:0] RTYPE_RELATIVE = 32'd8;

	localparam logic [63:0] WORD_BYTES   = 64'd8;
	localparam logic [63:0] RELR_STRIDE  = 64'd504;  // 63 words per bitmap
	localparam logic [5:0]  BIT_LAST_IDX = 6'd63;

	// One result command from the sequencer to the output register
	typedef struct packed {
		logic        fire;
		logic [63:0] addr;
		logic [63:0] val;
		erag_act_t   act;
		logic        last;
	} erag_emit_t;

endpackage

`default_nettype wire

### hw/rtl/erag_alu.sv
// Shared 64-bit adder with region check on operand a.
// Depends on nothing but its ports; used by erag_seq.
`default_nettype none

module erag_alu (
	input  wire logic [63:0] a,
	input  wire logic [63:0] b,
	input  wire logic [63:0] region_start,
	input  wire logic [63:0] region_end,
	output logic      [63:0] sum,
	output logic             in_range
);

	// Single adder; with b = 8 the sum is the word end for the bound check
	assign sum      = a + b;
	assign in_range = (a >= region_start) && (sum <= region_end);

endmodule

`default_nettype wire

### hw/rtl/erag_seq.sv
// Sequencer and item registers: decodes one entry and walks RELR bitmaps
// bit by bit through the shared adder. Uses erag_pkg and erag_alu.
`default_nettype none

module erag_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          mode,
	input  wire logic [63:0]         target_offset,
	input  wire logic [31:0]         reloc_type,
	input  wire logic signed [63:0]  addend,
	input  wire logic                table_start,
	input  wire logic [63:0]         image_base,
	input  wire logic [63:0]         region_start,
	input  wire logic [63:0]         region_end,
	input  wire logic                out_free,
	output erag_pkg::erag_emit_t     emit
);

	erag_pkg::erag_state_t state_q, state_d;

	logic [1:0]  mode_q;
	logic [63:0] word_q;
	logic [63:0] addend_q;
	logic        type_ok_q;
	logic [63:0] bitmap_q;
	logic [5:0]  bit_q;
	logic [63:0] relr_base_q;
	logic [63:0] addr_q;
	logic [63:0] val_q;
	logic        last_q;

	logic [63:0] alu_a, alu_b, alu_sum;
	logic        alu_in_range;
	logic        accept;
	logic        is_bitmap;
	logic [63:0] bitmap_rest;

	assign accept      = in_valid && !in_stall;
	assign is_bitmap   = (mode_q == erag_pkg::MODE_RELR) && word_q[0];
	assign bitmap_rest = bitmap_q & ~(64'd1 << bit_q);

	erag_alu u_alu (
		.a            (alu_a),
		.b            (alu_b),
		.region_start (region_start),
		.region_end   (region_end),
		.sum          (alu_sum),
		.in_range     (alu_in_range)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			erag_pkg::ST_IDLE: begin
				if (accept) state_d = erag_pkg::ST_DECODE;
			end
			erag_pkg::ST_DECODE: begin
				if ((mode_q == erag_pkg::MODE_RELA || mode_q == erag_pkg::MODE_REL)
				    && type_ok_q)
					state_d = erag_pkg::ST_ADDR;
				else if (mode_q == erag_pkg::MODE_RELR)
					state_d = word_q[0] ? erag_pkg::ST_SCAN : erag_pkg::ST_ADDR;
				else
					state_d = erag_pkg::ST_IDLE;
			end
			erag_pkg::ST_ADDR: begin
				state_d = (mode_q == erag_pkg::MODE_RELA) ? erag_pkg::ST_VAL
				                                          : erag_pkg::ST_EMIT;
			end
			erag_pkg::ST_VAL: state_d = erag_pkg::ST_EMIT;
			erag_pkg::ST_SCAN: begin
				if (bitmap_q[bit_q])          state_d = erag_pkg::ST_EMIT;
				else if (bit_q == erag_pkg::BIT_LAST_IDX) state_d = erag_pkg::ST_ADV;
			end
			erag_pkg::ST_EMIT: begin
				if (out_free) begin
					if (!is_bitmap)                          state_d = erag_pkg::ST_IDLE;
					else if (bit_q == erag_pkg::BIT_LAST_IDX) state_d = erag_pkg::ST_ADV;
					else                                     state_d = erag_pkg::ST_SCAN;
				end
			end
			erag_pkg::ST_ADV: state_d = erag_pkg::ST_IDLE;
			default: state_d = erag_pkg::ST_IDLE;
		endcase
	end

	// Outputs and adder operand select
	always_comb begin
		in_stall  = 1'b1;
		alu_a     = addr_q;
		alu_b     = erag_pkg::WORD_BYTES;
		emit.fire = 1'b0;
		emit.addr = addr_q;
		emit.val  = val_q;
		emit.last = last_q;
		emit.act  = erag_pkg::ACT_ADD;
		unique case (state_q)
			erag_pkg::ST_IDLE: in_stall = 1'b0;
			erag_pkg::ST_ADDR: begin
				alu_a = image_base;
				alu_b = word_q;
			end
			erag_pkg::ST_VAL: begin
				alu_a = image_base;
				alu_b = addend_q;
			end
			erag_pkg::ST_SCAN: begin
				alu_a = relr_base_q;
				alu_b = {55'd0, bit_q, 3'b000};
			end
			erag_pkg::ST_EMIT: begin
				emit.fire = out_free;
				if (!alu_in_range)                   emit.act = erag_pkg::ACT_SKIP;
				else if (mode_q == erag_pkg::MODE_RELA) emit.act = erag_pkg::ACT_STORE;
			end
			erag_pkg::ST_ADV: begin
				alu_a = relr_base_q;
				alu_b = erag_pkg::RELR_STRIDE;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= erag_pkg::ST_IDLE;
			bit_q       <= 6'd1;
			relr_base_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				erag_pkg::ST_IDLE: begin
					bit_q <= 6'd1;
					if (accept && table_start) relr_base_q <= '0;
				end
				erag_pkg::ST_ADDR: begin
					if (mode_q == erag_pkg::MODE_RELR) relr_base_q <= alu_sum;
				end
				erag_pkg::ST_SCAN: begin
					if (!bitmap_q[bit_q] && bit_q != erag_pkg::BIT_LAST_IDX)
						bit_q <= bit_q + 6'd1;
				end
				erag_pkg::ST_EMIT: begin
					if (out_free && is_bitmap && bit_q != erag_pkg::BIT_LAST_IDX)
						bit_q <= bit_q + 6'd1;
				end
				erag_pkg::ST_ADV: relr_base_q <= alu_sum;
				default: ;
			endcase
		end
	end

	// Item and command payload registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			erag_pkg::ST_IDLE: begin
				if (accept) begin
					mode_q    <= mode;
					word_q    <= target_offset;
					addend_q  <= addend;
					type_ok_q <= (reloc_type == erag_pkg::RTYPE_RELATIVE) ||
					             (reloc_type == erag_pkg::RTYPE_ABS64) ||
					             (reloc_type == erag_pkg::RTYPE_GLOB_DAT);
					bitmap_q  <= {target_offset[63:1], 1'b0};
				end
			end
			erag_pkg::ST_DECODE: begin
				val_q  <= image_base;
				last_q <= 1'b1;
			end
			erag_pkg::ST_ADDR: addr_q <= alu_sum;
			erag_pkg::ST_VAL:  val_q  <= alu_sum;
			erag_pkg::ST_SCAN: begin
				if (bitmap_q[bit_q]) begin
					addr_q   <= alu_sum;
					bitmap_q <= bitmap_rest;
					last_q   <= (bitmap_rest == '0);
				end
			end
			default: ;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == erag_pkg::ST_DECODE)
		else $error("accepted entry not decoded next cycle");

	a_bitmap_drained: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == erag_pkg::ST_ADV |-> bitmap_q == '0)
		else $error("base advanced with bitmap bits left");

	// After the last command only empty bitmap bits may still be scanned
	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.fire && emit.last) |=>
			(state_q == erag_pkg::ST_IDLE || state_q == erag_pkg::ST_ADV ||
			 (state_q == erag_pkg::ST_SCAN && bitmap_q == '0)))
		else $error("command after last of entry");

	a_bitmap_bit_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == erag_pkg::ST_EMIT && is_bitmap) |-> bit_q != 6'd0)
		else $error("bitmap emitted for bit zero");
`endif

endmodule

`default_nettype wire

### hw/rtl/elf_relocation_address_generator_top.sv
// Top level: configuration registers, sequencer and output command register.
// Depends on erag_pkg, erag_alu and erag_seq.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes image_base (0),
//    region_start (1) and region_end (2); cfg_ready is always high. Write only
//    while no entry is in flight.
//  - Input channel (in_valid/in_stall) takes one relocation entry per transfer.
//    in_stall stays high while an entry is being worked on.
//  - Output channel (out_valid/out_stall) gives store/add/skip commands, last
//    set on the final command of an entry. Entries producing nothing give no
//    transfer.
//  - Each entry runs through the sequencer steps in order on the one shared adder:
//    RELA decode, address, value, emit; REL and RELR address word decode, address,
//    emit; RELR bitmap decode, a scan of bits 1 to 63 with an emit per set bit,
//    then a base advance; unsupported types and unused mode decode only. Each emit
//    loads the output command register; output stalls hold the emit step.
//  - When the receiver stalls, the command holds in the output register and
//    the sequencer waits in its emit step.
//  - Reset clears the configuration registers, the kept RELR base and all valid flags.
`default_nettype none

module elf_relocation_address_generator_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [63:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [63:0]        target_offset,
	input  wire logic [31:0]        reloc_type,
	input  wire logic signed [63:0] addend,
	input  wire logic               table_start,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [63:0]             target_address,
	output logic [63:0]             update_value,
	output logic [1:0]              action,
	output logic                    last
);

	logic [63:0] image_base_q, region_start_q, region_end_q;
	logic        out_valid_q;
	logic        out_free;
	erag_pkg::erag_emit_t emit;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_base_q   <= '0;
			region_start_q <= '0;
			region_end_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (erag_pkg::erag_cfg_idx_t'(cfg_index))
				erag_pkg::CFG_IMAGE_BASE:   image_base_q   <= cfg_data;
				erag_pkg::CFG_REGION_START: region_start_q <= cfg_data;
				erag_pkg::CFG_REGION_END:   region_end_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	erag_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.target_offset (target_offset),
		.reloc_type    (reloc_type),
		.addend        (addend),
		.table_start   (table_start),
		.image_base    (image_base_q),
		.region_start  (region_start_q),
		.region_end    (region_end_q),
		.out_free      (out_free),
		.emit          (emit)
	);

	// Output command register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit.fire) begin
			target_address <= emit.addr;
			update_value   <= emit.val;
			action         <= emit.act;
			last           <= emit.last;
		end
	end

endmodule

`default_nettype wire

### tb/tb_elf_relocation_address_generator_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for elf_relocation_address_generator_top: RELA, REL and RELR
// entries are predicted into store/add/skip commands and checked. Needs erag_pkg and the RTL.

module tb_elf_relocation_address_generator_top;

	localparam logic [63:0] BYTES_PER_WORD = 64'd8;
	localparam logic [63:0] BITMAP_SPAN    = 64'd504;  // 63 words covered per bitmap
	localparam int          SETTLE_CYCLES  = 150;      // sequencer settle time after the last expected command

	// One relocation entry as offered on the input channel
	typedef struct packed {
		erag_pkg::erag_mode_t mode;
		logic [63:0]          offset;
		logic [31:0]          rtype;
		logic [63:0]          addend;
		logic                 tstart;
	} reloc_entry_t;

	// One memory update command as seen on the output channel
	typedef struct packed {
		logic [63:0]         addr;
		logic [63:0]         val;
		erag_pkg::erag_act_t act;
		logic                last;
	} update_cmd_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = erag_pkg::CFG_IMAGE_BASE;
	logic [63:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = erag_pkg::MODE_RELA;
	logic [63:0]        target_offset = '0;
	logic [31:0]        reloc_type = '0;
	logic signed [63:0] addend = '0;
	logic               table_start = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [63:0]        target_address;
	logic [63:0]        update_value;
	logic [1:0]         action;
	logic               last;

	// Stimulus and scoreboard state
	reloc_entry_t entries_pending[$];
	update_cmd_t  cmds_expected[$];
	reloc_entry_t drive_entry;
	update_cmd_t  seen_cmd;
	int           gap_left = 0;
	int           stall_left = 0;
	int           idle_odds = 0;
	int           mismatches = 0;
	logic         hold_req = 1'b0;
	logic         long_hold = 1'b0;

	// Predictor copy of the registers and the kept RELR base
	logic [63:0] cfg_image_base = '0;
	logic [63:0] cfg_region_start = '0;
	logic [63:0] cfg_region_end = '0;
	logic [63:0] relr_cursor = '0;

	elf_relocation_address_generator_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mode           (mode),
		.target_offset  (target_offset),
		.reloc_type     (reloc_type),
		.addend         (addend),
		.table_start    (table_start),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target_address (target_address),
		.update_value   (update_value),
		.action         (action),
		.last           (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic is_handled_type(logic [31:0] t);
		return t == erag_pkg::RTYPE_RELATIVE || t == erag_pkg::RTYPE_ABS64 ||
			t == erag_pkg::RTYPE_GLOB_DAT;
	endfunction

	// Out-of-region targets turn into skips; end bound wraps modulo 2^64
	function automatic erag_pkg::erag_act_t region_act(logic [63:0] a,
		erag_pkg::erag_act_t act);
		logic [63:0] a_end;
		a_end = a + BYTES_PER_WORD;
		if (a >= cfg_region_start && a_end <= cfg_region_end)
			return act;
		return erag_pkg::ACT_SKIP;
	endfunction

	// Work out the commands one entry causes and queue them
	task automatic predict_updates(input reloc_entry_t e);
		update_cmd_t cmds[$];
		logic [63:0] a;
		int b;
		if (e.tstart)
			relr_cursor = '0;
		case (e.mode)
			erag_pkg::MODE_RELA: begin
				if (is_handled_type(e.rtype)) begin
					a = cfg_image_base + e.offset;
					cmds.push_back('{a, cfg_image_base + e.addend,
						region_act(a, erag_pkg::ACT_STORE), 1'b0});
				end
			end
			erag_pkg::MODE_REL: begin
				if (is_handled_type(e.rtype)) begin
					a = cfg_image_base + e.offset;
					cmds.push_back('{a, cfg_image_base, region_act(a, erag_pkg::ACT_ADD),
						1'b0});
				end
			end
			erag_pkg::MODE_RELR: begin
				if (!e.offset[0]) begin
					relr_cursor = cfg_image_base + e.offset;
					cmds.push_back('{relr_cursor, cfg_image_base,
						region_act(relr_cursor, erag_pkg::ACT_ADD), 1'b0});
				end else begin
					for (b = 1; b < 64; b++) begin
						if (e.offset[b]) begin
							a = relr_cursor + 64'(b) * BYTES_PER_WORD;
							cmds.push_back('{a, cfg_image_base,
								region_act(a, erag_pkg::ACT_ADD), 1'b0});
						end
					end
					relr_cursor = relr_cursor + BITMAP_SPAN;
				end
			end
			default: ;
		endcase
		if (cmds.size() != 0)
			cmds[cmds.size() - 1].last = 1'b1;
		foreach (cmds[i])
			cmds_expected.push_back(cmds[i]);
	endtask

	// Input driver: payload holds while stalled, random gaps between transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else if (!in_valid || !in_stall) begin
			if (gap_left != 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
				in_valid <= 1'b0;
				gap_left <= $urandom_range(0, 3);
			end else if (entries_pending.size() != 0) begin
				drive_entry = entries_pending.pop_front();
				in_valid <= 1'b1;
				mode <= drive_entry.mode;
				target_offset <= drive_entry.offset;
				reloc_type <= drive_entry.rtype;
				addend <= drive_entry.addend;
				table_start <= drive_entry.tstart;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output receiver: random stall bursts, plus one long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (long_hold) begin
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Long receiver hold-off so the block backs up into its input
	initial begin
		wait (hold_req);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (400) @(posedge clk);
		long_hold <= 1'b0;
	end

	// Monitor: check output transfers first, then track config and input transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (cmds_expected.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected command addr %h val %h act %0d last %0b",
							$realtime, target_address, update_value, action, last);
				end else begin
					seen_cmd = cmds_expected.pop_front();
					if (seen_cmd.addr !== target_address || seen_cmd.val !== update_value ||
					    seen_cmd.act !== action || seen_cmd.last !== last) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("%0t: command mismatch: expected addr %h val %h act %0d ",
								$realtime, seen_cmd.addr, seen_cmd.val, seen_cmd.act);
							$display("last %0b, got addr %h val %h act %0d last %0b",
								seen_cmd.last, target_address, update_value, action, last);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					erag_pkg::CFG_IMAGE_BASE:   cfg_image_base = cfg_data;
					erag_pkg::CFG_REGION_START: cfg_region_start = cfg_data;
					erag_pkg::CFG_REGION_END:   cfg_region_end = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				predict_updates('{erag_pkg::erag_mode_t'(mode), target_offset, reloc_type,
					addend, table_start});
		end
	end

	task automatic queue_entry(input erag_pkg::erag_mode_t m, input logic [63:0] off,
		input logic [31:0] t, input logic [63:0] add, input logic ts);
		entries_pending.push_back('{m, off, t, add, ts});
	endtask

	// Waits for all transfers to finish, then lets the sequencer settle
	task automatic wait_idle();
		while (entries_pending.size() != 0 || in_valid || cmds_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input erag_pkg::erag_cfg_idx_t idx,
		input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_region(input logic [63:0] base, input logic [63:0] lo,
		input logic [63:0] hi);
		write_register(erag_pkg::CFG_IMAGE_BASE, base);
		write_register(erag_pkg::CFG_REGION_START, lo);
		write_register(erag_pkg::CFG_REGION_END, hi);
		@(negedge clk);
	endtask

	function automatic logic [63:0] pick_offset();
		if ($urandom_range(0, 7) == 0)
			return rand64();
		return 64'($urandom_range(0, 'h9000)) & ~64'd7;
	endfunction

	function automatic logic [31:0] pick_type();
		case ($urandom_range(0, 5))
			0: return erag_pkg::RTYPE_RELATIVE;
			1: return erag_pkg::RTYPE_ABS64;
			2: return erag_pkg::RTYPE_GLOB_DAT;
			3: return erag_pkg::RTYPE_RELATIVE;
			4: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	// Random mix: mostly well-formed RELA/REL entries and RELR tables, some noise
	task automatic queue_random_entries(input int count);
		reloc_entry_t e;
		int left;
		int kind;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			e = '{erag_pkg::MODE_RELA, pick_offset(), pick_type(), rand64(),
				($urandom_range(0, 7) == 0)};
			if (kind <= 2) begin
				entries_pending.push_back(e);
				left--;
			end else if (kind <= 4) begin
				e.mode = erag_pkg::MODE_REL;
				entries_pending.push_back(e);
				left--;
			end else if (kind <= 8) begin
				// RELR table: address word followed by a run of bitmaps
				e.mode = erag_pkg::MODE_RELR;
				e.offset = pick_offset() & ~64'd1;
				e.tstart = ($urandom_range(0, 3) != 0);
				entries_pending.push_back(e);
				left--;
				repeat ($urandom_range(1, 4)) begin
					e.offset = ($urandom_range(0, 4) == 0) ? rand64() :
						rand64() & rand64() & rand64();
					e.offset[0] = 1'b1;
					e.tstart = ($urandom_range(0, 15) == 0);
					e.rtype = $urandom;
					e.addend = rand64();
					entries_pending.push_back(e);
					left--;
				end
			end else begin
				e.mode = erag_pkg::erag_mode_t'($urandom_range(0, 3));
				e.offset = rand64();
				e.rtype = $urandom;
				e.tstart = 1'($urandom_range(0, 1));
				entries_pending.push_back(e);
				left--;
			end
		end
	endtask

	initial begin
		logic [63:0] base;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Registers at reset: empty region, only a wrapping end bound passes
		idle_odds = 4;
		queue_entry(erag_pkg::MODE_RELA, 64'h100, erag_pkg::RTYPE_RELATIVE, 64'd5, 1'b0);
		queue_entry(erag_pkg::MODE_RELA, 64'hFFFF_FFFF_FFFF_FFF8, erag_pkg::RTYPE_ABS64,
			64'h10, 1'b0);
		wait_idle();

		// Directed entries around a 1 MiB region at the image base
		set_region(64'h4000_0000, 64'h4000_0000, 64'h4010_0000);
		queue_entry(erag_pkg::MODE_RELA, 64'h10, erag_pkg::RTYPE_RELATIVE, 64'h20, 1'b0);
		queue_entry(erag_pkg::MODE_RELA, 64'h18, erag_pkg::RTYPE_GLOB_DAT,
			64'h8000_0000_0000_0000, 1'b0);
		queue_entry(erag_pkg::MODE_RELA, 64'h20, erag_pkg::RTYPE_ABS64,
			64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
		queue_entry(erag_pkg::MODE_RELA, 64'h28, 32'd7, 64'h1, 1'b0);
		queue_entry(erag_pkg::MODE_RELA, 64'h30, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
		queue_entry(erag_pkg::MODE_RELA, 64'h38, 32'd0, 64'h0, 1'b0);
		queue_entry(erag_pkg::MODE_REL, 64'h40, erag_pkg::RTYPE_RELATIVE, 64'h55, 1'b0);
		queue_entry(erag_pkg::MODE_REL, 64'h48, 32'd2, 64'h0, 1'b0);
		queue_entry(erag_pkg::MODE_REL, 64'hF_FFFC, erag_pkg::RTYPE_ABS64, 64'h0, 1'b0);
		// last word that still fits below the end bound
		queue_entry(erag_pkg::MODE_RELA, 64'hF_FFF8, erag_pkg::RTYPE_RELATIVE, 64'h0, 1'b0);
		// below region start
		queue_entry(erag_pkg::MODE_RELA, 64'hFFFF_FFFF_FFFF_FFFF, erag_pkg::RTYPE_GLOB_DAT,
			64'h0, 1'b0);
		queue_entry(erag_pkg::MODE_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 64'h1,
			1'b0);
		// RELR table: address word, full bitmap, empty bitmap, ends-only bitmap
		queue_entry(erag_pkg::MODE_RELR, 64'h1000, 32'd0, 64'h0, 1'b1);
		queue_entry(erag_pkg::MODE_RELR, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 64'h0, 1'b0);
		queue_entry(erag_pkg::MODE_RELR, 64'h1, 32'd0, 64'h0, 1'b0);
		queue_entry(erag_pkg::MODE_RELR, 64'h8000_0000_0000_0003, 32'd0, 64'h0, 1'b0);
		// unused mode still clears the kept base
		queue_entry(erag_pkg::MODE_UNUSED, 64'h0, 32'd0, 64'h0, 1'b1);
		queue_entry(erag_pkg::MODE_RELR, 64'h5, 32'd0, 64'h0, 1'b0);
		queue_entry(erag_pkg::MODE_RELR, 64'hB, erag_pkg::RTYPE_RELATIVE, 64'h0, 1'b1);
		// address word that wraps below the region
		queue_entry(erag_pkg::MODE_RELR, 64'hFFFF_FFFF_FFFF_FFFE, 32'd0, 64'h0, 1'b0);
		queue_entry(erag_pkg::MODE_RELR, 64'h3, 32'd0, 64'h0, 1'b0);
		wait_idle();

		// Zero base, whole address space writable
		write_register(erag_pkg::CFG_RSVD, rand64());
		set_region(64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
		idle_odds = 3;
		queue_random_entries(100);
		wait_idle();

		// All-ones extremes: nearly everything is skipped
		set_region(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		idle_odds = 8;
		queue_random_entries(60);
		wait_idle();

		// Random base with a region inside the offset range, plus a long hold-off
		base = rand64();
		set_region(base, base + 64'h100, base + 64'h8000);
		idle_odds = 5;
		queue_random_entries(120);
		hold_req = 1'b1;
		wait_idle();

		// Closing stretch at full rate
		base = rand64();
		set_region(base, base, base + 64'h4000);
		idle_odds = 0;
		queue_random_entries(80);
		wait_idle();

		if (mismatches == 0 && cmds_expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
